[design/nzcs_pkg.sv]
// nzcs_pkg: shared constants, types and state codes for the nearest zero-crossing search.
// No dependencies; used by nzcs_front, nzcs_back and nearest_zero_crossing_search.
`default_nettype none

package nzcs_pkg;

  localparam int MAX_WINDOW_DEF  = 255;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAME_W         = 40;
  localparam int CFG_W           = 8;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_FRAMES = 1'b0;

  typedef struct packed {
    logic               present;
    logic               last;
    logic [FRAME_W-1:0] req;
  } item_ctrl_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_SEARCH,
    BK_RESULT
  } back_state_t;

endpackage

`default_nettype wire

[design/nzcs_front.sv]
// nzcs_front: accepts frame items, forms left+right and queues them for the back end.
// Depends on nzcs_pkg (item_ctrl_t, FRAME_W).
`default_nettype none

module nzcs_front #(
  parameter int SAMPLE_BITS = nzcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
  input  wire logic                          present,
  input  wire logic [nzcs_pkg::FRAME_W-1:0]  requested_frame,
  input  wire logic                          last,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output logic [SAMPLE_BITS:0]               q_sum,
  output nzcs_pkg::item_ctrl_t               q_ctrl
);

  localparam int SW = SAMPLE_BITS + 1;

  logic [SW-1:0]        sum_q  [2];
  nzcs_pkg::item_ctrl_t ctrl_q [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;
  logic [SW-1:0]        sum_in;

  assign sum_in   = {left_sample[SAMPLE_BITS-1], left_sample}
                  + {right_sample[SAMPLE_BITS-1], right_sample};
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_sum    = sum_q[rd_ptr];
  assign q_ctrl   = ctrl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum_q[wr_ptr]  <= sum_in;
      ctrl_q[wr_ptr] <= '{present: present, last: last, req: requested_frame};
    end
  end

endmodule

`default_nettype wire

[design/nzcs_back.sv]
// nzcs_back: window memory, outward pair search and result register.
// Depends on nzcs_pkg (back_state_t, item_ctrl_t, FRAME_W, CFG_W).
`default_nettype none

module nzcs_back #(
  parameter int MAX_WINDOW  = nzcs_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = nzcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [nzcs_pkg::CFG_W-1:0]   window_frames,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire logic [SAMPLE_BITS:0]         q_sum,
  input  wire nzcs_pkg::item_ctrl_t         q_ctrl,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [nzcs_pkg::FRAME_W-1:0]      chosen_frame,
  output logic                              found
);

  localparam int SW     = SAMPLE_BITS + 1;
  localparam int DEPTH  = 2 * MAX_WINDOW + 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FW     = nzcs_pkg::FRAME_W;

  nzcs_pkg::back_state_t state, state_next;

  logic [SW:0]       mem [DEPTH];
  logic [CNT_W-1:0]  load_count;
  logic [ADDR_W-1:0] w_eff;
  logic [ADDR_W-1:0] e;
  logic              phase;
  logic              iss_on;
  logic [ADDR_W-1:0] lo;
  logic              last_step;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_lo;
  logic              rd_last;
  logic [SW:0]       rd_a;
  logic [SW:0]       rd_b;
  logic [FW-1:0]     req_reg;
  logic              res_found;
  logic [ADDR_W-1:0] res_pos;
  logic              out_load;
  logic              room;

  logic [SW-1:0]     a_sum, b_sum, mag_a, mag_b;
  logic              a_zero, b_zero, pair_ok, hit, hit_hi;
  logic [CNT_W-1:0]  hi;
  logic [ADDR_W-1:0] hit_pos;

  assign w_eff = (int'(window_frames) > MAX_WINDOW) ? ADDR_W'(MAX_WINDOW)
                                                    : ADDR_W'(window_frames);
  assign room      = (load_count < CNT_W'(DEPTH));
  assign lo        = phase ? (w_eff - e) : (w_eff + e);
  assign last_step = phase && (e == w_eff);

  // pair test on registered read data
  assign a_sum   = rd_a[SW-1:0];
  assign b_sum   = rd_b[SW-1:0];
  assign mag_a   = a_sum[SW-1] ? (~a_sum + SW'(1)) : a_sum;
  assign mag_b   = b_sum[SW-1] ? (~b_sum + SW'(1)) : b_sum;
  assign a_zero  = (a_sum == '0);
  assign b_zero  = (b_sum == '0);
  assign hi      = CNT_W'(rd_lo) + CNT_W'(1);
  assign pair_ok = rd_valid && (hi < load_count) && rd_a[SW] && rd_b[SW];
  assign hit     = pair_ok && (a_zero || b_zero || (a_sum[SW-1] != b_sum[SW-1]));
  assign hit_hi  = !a_zero && (b_zero || (mag_a > mag_b));
  assign hit_pos = rd_lo + ADDR_W'(hit_hi);

  always_comb begin
    state_next = state;
    unique case (state)
      nzcs_pkg::BK_LOAD: begin
        if (q_valid && q_ctrl.last)
          state_next = (w_eff == '0) ? nzcs_pkg::BK_RESULT : nzcs_pkg::BK_SEARCH;
      end
      nzcs_pkg::BK_SEARCH: begin
        if (rd_valid && (hit || rd_last)) state_next = nzcs_pkg::BK_RESULT;
      end
      nzcs_pkg::BK_RESULT: begin
        if (!out_valid || !out_stall) state_next = nzcs_pkg::BK_LOAD;
      end
      default: state_next = nzcs_pkg::BK_LOAD;
    endcase
  end

  always_comb begin
    q_pop    = (state == nzcs_pkg::BK_LOAD) && q_valid;
    out_load = (state == nzcs_pkg::BK_RESULT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nzcs_pkg::BK_LOAD;
      load_count <= '0;
      iss_on     <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && room) load_count <= load_count + CNT_W'(1);
      if (out_load) load_count <= '0;
      if (q_pop && q_ctrl.last) iss_on <= 1'b1;
      else if (state == nzcs_pkg::BK_SEARCH && iss_on && last_step) iss_on <= 1'b0;
      rd_valid <= (state == nzcs_pkg::BK_SEARCH) && iss_on;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && room) mem[ADDR_W'(load_count)] <= {q_ctrl.present, q_sum};
    if (q_pop && q_ctrl.last) begin
      req_reg   <= q_ctrl.req;
      e         <= '0;
      phase     <= 1'b0;
      res_found <= 1'b0;
    end
    if (state == nzcs_pkg::BK_SEARCH) begin
      if (iss_on) begin
        rd_a    <= mem[lo];
        rd_b    <= mem[lo + ADDR_W'(1)];
        rd_lo   <= lo;
        rd_last <= last_step;
        if (!phase && e != '0) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          e     <= e + ADDR_W'(1);
        end
      end
      if (hit) begin
        res_found <= 1'b1;
        res_pos   <= hit_pos;
      end
    end
    if (out_load) begin
      chosen_frame <= res_found ? (req_reg + FW'(res_pos) - FW'(w_eff) - FW'(1)) : req_reg;
      found        <= res_found;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(DEPTH))
    else $error("load count beyond window depth");
  a_search_w: assert property (@(posedge clk) disable iff (rst)
    state == nzcs_pkg::BK_SEARCH |-> w_eff != '0)
    else $error("search running with zero window");
  a_lo_range: assert property (@(posedge clk) disable iff (rst)
    (state == nzcs_pkg::BK_SEARCH && rd_valid) |-> {1'b0, rd_lo} <= {w_eff, 1'b0})
    else $error("pair index outside window");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> load_count == '0)
    else $error("load count not cleared after result");
  a_hit: assert property (@(posedge clk) disable iff (rst)
    (state == nzcs_pkg::BK_SEARCH && hit) |=> state == nzcs_pkg::BK_RESULT && res_found)
    else $error("crossing not carried to result");
`endif

endmodule

`default_nettype wire

[design/nearest_zero_crossing_search.sv]
// Channel   Direction  Handshake            Payload
// frames    in         in_valid/in_stall    left_sample right_sample present requested_frame last
// result    out        out_valid/out_stall  chosen_frame found
// config    APB        psel/penable/pready  window_frames at byte address 0
//
// Each frame item passes through the two-entry queue into the window memory.
// An item with last starts the outward search: up to 2W+1 pair tests, one per cycle
// from the dual-read window memory; the search stops at the first crossing pair, and
// out_valid rises once the result register is free; with W zero no search runs.
// rst is synchronous; the window memory needs no clearing, the load count masks it.
// The input stalls once the queue is full while a search runs or a result waits.
// Depends on nzcs_pkg, nzcs_front and nzcs_back.
`default_nettype none

module nearest_zero_crossing_search #(
  parameter int MAX_WINDOW  = nzcs_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = nzcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nzcs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [nzcs_pkg::PDATA_W-1:0]    pwdata,
  output logic [nzcs_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  wire logic signed [SAMPLE_BITS-1:0]   left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   right_sample,
  input  wire logic                            present,
  input  wire logic [nzcs_pkg::FRAME_W-1:0]    requested_frame,
  input  wire logic                            last,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  output logic [nzcs_pkg::FRAME_W-1:0]         chosen_frame,
  output logic                                 found,
  output logic                                 out_valid,
  input  wire logic                            out_stall
);

  logic [nzcs_pkg::CFG_W-1:0] window_frames;
  logic                       q_valid;
  logic                       q_pop;
  logic [SAMPLE_BITS:0]       q_sum;
  nzcs_pkg::item_ctrl_t       q_ctrl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nzcs_pkg::REG_WINDOW_FRAMES)
                ? nzcs_pkg::PDATA_W'(window_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nzcs_pkg::REG_WINDOW_FRAMES) begin
      window_frames <= pwdata[nzcs_pkg::CFG_W-1:0];
    end
  end

  nzcs_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .present        (present),
    .requested_frame(requested_frame),
    .last           (last),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_sum          (q_sum),
    .q_ctrl         (q_ctrl)
  );

  nzcs_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .window_frames(window_frames),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_sum        (q_sum),
    .q_ctrl       (q_ctrl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_frame (chosen_frame),
    .found        (found)
  );

endmodule

`default_nettype wire
